FILE: rtl/assert_macros.svh
// Assertion helpers shared by the RTL. Each expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset
`define ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/bttj_pkg.sv
`timescale 1ns / 1ps

package bttj_pkg;

  // Field widths
  localparam int TAG_W     = 6;
  localparam int MOM_W     = 16;
  localparam int OUT_IDX_W = 6;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 16;

  // Default jet limit per event
  localparam int MAX_JETS_DEF = 64;

  // Medium tag bit masks
  localparam logic [TAG_W-1:0] TAG_MASK_LOOSE = 6'b000010;
  localparam logic [TAG_W-1:0] TAG_MASK_ALT   = 6'b010000;

  // One input jet word
  typedef struct packed {
    logic             last_jet;
    logic [MOM_W-1:0] jet_momentum;
    logic [TAG_W-1:0] tag_bits;
  } in_word_t;

  // One event result, found in the lowest bit
  typedef struct packed {
    logic                 overflow;
    logic [OUT_IDX_W-1:0] sublead_index;
    logic [OUT_IDX_W-1:0] lead_index;
    logic                 found;
  } rslt_t;

endpackage

FILE: rtl/bttj_in_reg.sv
`timescale 1ns / 1ps

// Input register: holds one jet word until the ranking stage takes it.
module bttj_in_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  bttj_pkg::in_word_t in_word,
  input  logic              take,
  output logic              vld,
  output bttj_pkg::in_word_t word
);

  logic               vld_r, vld_nxt;
  bttj_pkg::in_word_t word_r;

  // free when empty or emptied this cycle
  assign in_tready = !vld_r || take;
  assign vld_nxt   = in_tvalid ? 1'b1 : (take ? 1'b0 : vld_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_tready) begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      word_r <= in_word;
    end
  end

  assign vld  = vld_r;
  assign word = word_r;

endmodule

FILE: rtl/bttj_rank.sv
`timescale 1ns / 1ps

`include "assert_macros.svh"

// Event state: best and second-best jet, one compare-and-update per word.
module bttj_rank #(
  parameter int MAX_JETS = bttj_pkg::MAX_JETS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               process,
  input  bttj_pkg::in_word_t word,
  input  logic               use_mtd,
  output bttj_pkg::rslt_t    rslt
);

  localparam int CNT_W = $clog2(MAX_JETS + 1);
  localparam int IW    = bttj_pkg::OUT_IDX_W;
  localparam int MW    = bttj_pkg::MOM_W;

  logic [CNT_W-1:0] jet_count_r, jet_count_nxt, jet_count_upd;
  logic             second_valid_r, second_valid_nxt, second_valid_upd;
  logic             overflow_seen_r, overflow_seen_nxt, overflow_seen_upd;
  logic [IW-1:0]    best_index_r, best_index_nxt;
  logic             best_tag_r, best_tag_nxt;
  logic [MW-1:0]    best_momentum_r, best_momentum_nxt;
  logic [IW-1:0]    second_index_r, second_index_nxt;
  logic             second_tag_r, second_tag_nxt;
  logic [MW-1:0]    second_momentum_r, second_momentum_nxt;

  logic             tag_new;
  logic [IW-1:0]    idx_new;
  logic             full;
  logic             beats_best;
  logic             beats_second;

  // strict key order: tag, then momentum
  function automatic logic key_gt(input logic ta, input logic [MW-1:0] ma,
                                  input logic tb, input logic [MW-1:0] mb);
    logic r;
    if (ta != tb) begin
      r = ta;
    end else begin
      r = (ma > mb);
    end
    return r;
  endfunction

  assign tag_new = use_mtd ? |(word.tag_bits & bttj_pkg::TAG_MASK_ALT)
                           : |(word.tag_bits & bttj_pkg::TAG_MASK_LOOSE);
  assign idx_new = IW'(jet_count_r);
  assign full    = (jet_count_r == CNT_W'(MAX_JETS));

  assign beats_best   = key_gt(tag_new, word.jet_momentum, best_tag_r, best_momentum_r);
  assign beats_second = key_gt(tag_new, word.jet_momentum, second_tag_r, second_momentum_r);

  // single-pass update of the two slots
  always_comb begin
    jet_count_upd       = jet_count_r;
    second_valid_upd    = second_valid_r;
    overflow_seen_upd   = overflow_seen_r;
    best_index_nxt      = best_index_r;
    best_tag_nxt        = best_tag_r;
    best_momentum_nxt   = best_momentum_r;
    second_index_nxt    = second_index_r;
    second_tag_nxt      = second_tag_r;
    second_momentum_nxt = second_momentum_r;
    if (process) begin
      if (full) begin
        overflow_seen_upd = 1'b1;
      end else begin
        priority if (jet_count_r == '0) begin
          best_index_nxt    = idx_new;
          best_tag_nxt      = tag_new;
          best_momentum_nxt = word.jet_momentum;
        end else if (beats_best) begin
          second_valid_upd    = 1'b1;
          second_index_nxt    = best_index_r;
          second_tag_nxt      = best_tag_r;
          second_momentum_nxt = best_momentum_r;
          best_index_nxt      = idx_new;
          best_tag_nxt        = tag_new;
          best_momentum_nxt   = word.jet_momentum;
        end else if (!second_valid_r || beats_second) begin
          second_valid_upd    = 1'b1;
          second_index_nxt    = idx_new;
          second_tag_nxt      = tag_new;
          second_momentum_nxt = word.jet_momentum;
        end else begin
          second_valid_upd = second_valid_r;
        end
        jet_count_upd = jet_count_r + CNT_W'(1);
      end
    end
  end

  // result from the updated slots; a tie in momentum makes the second the lead
  always_comb begin
    rslt.found         = second_valid_upd;
    rslt.overflow      = overflow_seen_upd;
    rslt.lead_index    = '0;
    rslt.sublead_index = '0;
    if (second_valid_upd) begin
      if (best_momentum_nxt > second_momentum_nxt) begin
        rslt.lead_index    = best_index_nxt;
        rslt.sublead_index = second_index_nxt;
      end else begin
        rslt.lead_index    = second_index_nxt;
        rslt.sublead_index = best_index_nxt;
      end
    end
  end

  // last jet closes the event
  always_comb begin
    jet_count_nxt     = jet_count_upd;
    second_valid_nxt  = second_valid_upd;
    overflow_seen_nxt = overflow_seen_upd;
    if (process && word.last_jet) begin
      jet_count_nxt     = '0;
      second_valid_nxt  = 1'b0;
      overflow_seen_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      jet_count_r     <= '0;
      second_valid_r  <= 1'b0;
      overflow_seen_r <= 1'b0;
    end else begin
      jet_count_r     <= jet_count_nxt;
      second_valid_r  <= second_valid_nxt;
      overflow_seen_r <= overflow_seen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    best_index_r      <= best_index_nxt;
    best_tag_r        <= best_tag_nxt;
    best_momentum_r   <= best_momentum_nxt;
    second_index_r    <= second_index_nxt;
    second_tag_r      <= second_tag_nxt;
    second_momentum_r <= second_momentum_nxt;
  end

  `ASSERT_SAME(a_cnt_bound, 1'b1, jet_count_r <= CNT_W'(MAX_JETS), "jet count beyond limit")
  `ASSERT_SAME(a_second_cnt, second_valid_r, jet_count_r >= CNT_W'(2), "second slot with < 2 jets")
  `ASSERT_NEXT(a_event_clr, process && word.last_jet,
               jet_count_r == '0 && !second_valid_r && !overflow_seen_r, "event not cleared")

endmodule

FILE: rtl/best_two_tagged_jet_select.sv
`timescale 1ns / 1ps

`include "assert_macros.svh"

// Best-two tagged jet selector.
// Jets of one event stream in on the in_ channel, one word per jet; in_tlast
// marks the final jet. Each jet is ranked by its medium tag bit (bit 1, or
// bit 4 when use_mtd is set through cfg_we/cfg_wdata) and then by momentum.
// On the last jet one result word leaves on the out_ channel: found flag,
// lead and sublead indices, and an overflow flag for jets past MAX_JETS.
// A jet is registered on entry and ranked when it leaves the input register;
// the result word is registered when the last jet is ranked.
// Throughput: one jet per cycle while no last jet waits on a held result, set
// by the single compare-and-update of the two held slots; the result register
// frees the input side while a finished word waits.
// When out_tready is low with a result held, non-last jets still flow; a
// last jet waits in the input register, and in_tready drops once it is full.
// Reset (rst_n low, synchronous) empties both registers, clears the event
// state and sets use_mtd to 0.
module best_two_tagged_jet_select #(
  parameter int MAX_JETS = bttj_pkg::MAX_JETS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic                            cfg_wdata,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [bttj_pkg::IN_DATA_W-1:0]  in_tdata,  // tag_bits[5:0], jet_momentum[21:6], 0
  input  logic                            in_tlast,  // last_jet
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [bttj_pkg::OUT_DATA_W-1:0] out_tdata  // found[0], lead_index[6:1],
                                                     // sublead_index[12:7], overflow[13], 0
);

  localparam int TW = bttj_pkg::TAG_W;
  localparam int MW = bttj_pkg::MOM_W;

  logic               use_mtd_r;
  bttj_pkg::in_word_t in_word;
  bttj_pkg::in_word_t word;
  logic               word_vld;
  logic               out_free;
  logic               take;
  logic               load;
  bttj_pkg::rslt_t    rslt;
  bttj_pkg::rslt_t    rslt_r;
  logic               out_vld_r, out_vld_nxt;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      use_mtd_r <= 1'b0;
    end else if (cfg_we) begin
      use_mtd_r <= cfg_wdata;
    end
  end

  // unpack the input word
  assign in_word.tag_bits     = in_tdata[TW-1:0];
  assign in_word.jet_momentum = in_tdata[TW+MW-1:TW];
  assign in_word.last_jet     = in_tlast;

  bttj_in_reg u_in_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_word   (in_word),
    .take      (take),
    .vld       (word_vld),
    .word      (word)
  );

  // a last jet needs room in the result register
  assign out_free = !out_vld_r || out_tready;
  assign take     = word_vld && (!word.last_jet || out_free);
  assign load     = take && word.last_jet;

  bttj_rank #(
    .MAX_JETS (MAX_JETS)
  ) u_rank (
    .clk     (clk),
    .rst_n   (rst_n),
    .process (take),
    .word    (word),
    .use_mtd (use_mtd_r),
    .rslt    (rslt)
  );

  // result register
  assign out_vld_nxt = load ? 1'b1 : (out_tready ? 1'b0 : out_vld_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rslt_r <= rslt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {{(bttj_pkg::OUT_DATA_W - $bits(bttj_pkg::rslt_t)){1'b0}}, rslt_r};

  `ASSERT_SAME(a_load_room, load, !out_vld_r || out_tready, "result overwritten")
  `ASSERT_NEXT(a_out_src, !out_vld_r && !load, !out_tvalid, "result word without last jet")
  `ASSERT_SAME(a_stall_src, !in_tready, word_vld && word.last_jet && out_vld_r && !out_tready,
               "input stalled without cause")

endmodule

FILE: test/bttj_pick_checker.sv
`timescale 1ns / 1ps

// Watches the config port and both stream channels of the jet selector,
// ranks every accepted jet word itself and checks each result word against
// the oldest predicted pick.
module bttj_pick_checker #(
  parameter int MAX_JETS = bttj_pkg::MAX_JETS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic                            cfg_wdata,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  input  logic [bttj_pkg::IN_DATA_W-1:0]  in_tdata,   // tag_bits, jet_momentum, 0
  input  logic                            in_tlast,   // last_jet
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic [bttj_pkg::OUT_DATA_W-1:0] out_tdata,  // found, lead, sublead, overflow, 0
  output int                              mismatches,
  output int                              pending_picks
);
  import bttj_pkg::*;

  // Mode register copy: selects bit 4 instead of bit 1 as the medium tag
  logic             alt_tag;

  // Running event state
  int               n_jets;
  int               top_idx;
  logic             top_tag;
  logic [MOM_W-1:0] top_mom;
  logic             run_ok;
  int               run_idx;
  logic             run_tag;
  logic [MOM_W-1:0] run_mom;
  logic             spill;

  rslt_t            expected_picks[$];

  assign pending_picks = expected_picks.size();

  task automatic flag_mismatch(input string what, input int got, input int want);
    $display("%0t ns: mismatch in %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    mismatches++;
  endtask

  // Strict ordering: tag first, then momentum; equal keys keep the earlier jet
  function automatic bit outranks(input logic ta, input logic [MOM_W-1:0] ma,
                                  input logic tb, input logic [MOM_W-1:0] mb);
    if (ta != tb)
      return ta;
    return ma > mb;
  endfunction

  task automatic clear_event();
    n_jets  = 0;
    top_idx = 0;
    top_tag = 1'b0;
    top_mom = '0;
    run_ok  = 1'b0;
    run_idx = 0;
    run_tag = 1'b0;
    run_mom = '0;
    spill   = 1'b0;
  endtask

  // Fold one jet into the held pair; on the last jet queue the pick
  task automatic rank_jet(input in_word_t w);
    logic [TAG_W-1:0] mask;
    logic             tag_hit;
    rslt_t            pick;
    mask    = alt_tag ? TAG_MASK_ALT : TAG_MASK_LOOSE;
    tag_hit = |(w.tag_bits & mask);
    if (n_jets >= MAX_JETS) begin
      spill = 1'b1;
    end else begin
      if (n_jets == 0) begin
        top_idx = 0;
        top_tag = tag_hit;
        top_mom = w.jet_momentum;
      end else if (outranks(tag_hit, w.jet_momentum, top_tag, top_mom)) begin
        run_ok  = 1'b1;
        run_idx = top_idx;
        run_tag = top_tag;
        run_mom = top_mom;
        top_idx = n_jets;
        top_tag = tag_hit;
        top_mom = w.jet_momentum;
      end else if (!run_ok || outranks(tag_hit, w.jet_momentum, run_tag, run_mom)) begin
        run_ok  = 1'b1;
        run_idx = n_jets;
        run_tag = tag_hit;
        run_mom = w.jet_momentum;
      end
      n_jets++;
    end
    if (w.last_jet) begin
      pick = '0;
      if (run_ok) begin
        pick.found = 1'b1;
        // equal momenta put the runner-up in front
        if (top_mom > run_mom) begin
          pick.lead_index    = OUT_IDX_W'(top_idx);
          pick.sublead_index = OUT_IDX_W'(run_idx);
        end else begin
          pick.lead_index    = OUT_IDX_W'(run_idx);
          pick.sublead_index = OUT_IDX_W'(top_idx);
        end
      end
      pick.overflow = spill;
      expected_picks.push_back(pick);
      clear_event();
    end
  endtask

  // Sample everything at the rising edge
  always @(posedge clk) begin
    rslt_t    got;
    rslt_t    want;
    in_word_t w;
    if (!rst_n) begin
      alt_tag    = 1'b0;
      mismatches = 0;
      clear_event();
      expected_picks.delete();
    end else begin
      if (cfg_we)
        alt_tag = cfg_wdata;
      if (in_tvalid && in_tready) begin
        w.tag_bits     = in_tdata[TAG_W-1:0];
        w.jet_momentum = in_tdata[TAG_W +: MOM_W];
        w.last_jet     = in_tlast;
        rank_jet(w);
      end
      if (out_tvalid && out_tready) begin
        got = rslt_t'(out_tdata[$bits(rslt_t)-1:0]);
        if (expected_picks.size() == 0) begin
          flag_mismatch("unexpected result word", int'(out_tdata), 0);
        end else begin
          want = expected_picks.pop_front();
          if (got.found != want.found)
            flag_mismatch("found", int'(got.found), int'(want.found));
          if (got.lead_index != want.lead_index)
            flag_mismatch("lead_index", int'(got.lead_index), int'(want.lead_index));
          if (got.sublead_index != want.sublead_index)
            flag_mismatch("sublead_index", int'(got.sublead_index),
                          int'(want.sublead_index));
          if (got.overflow != want.overflow)
            flag_mismatch("overflow", int'(got.overflow), int'(want.overflow));
        end
      end
    end
  end

endmodule

FILE: test/best_two_tagged_jet_select_tb.sv
`timescale 1ns / 1ps

// Drives jet events into the selector in random bursts, stalls the result
// side on its own pattern and gives the verdict from the checker's count.
module best_two_tagged_jet_select_tb;
  import bttj_pkg::*;

  typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_BEAT} rx_mode_e;

  localparam int RANDOM_JETS = 1400;
  localparam int LONG_HOLD   = 300;
  localparam int DRAIN_LIMIT = 20000;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  cfg_we     = 1'b0;
  logic                  cfg_wdata  = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic                  in_tlast   = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;

  int                    mismatches;
  int                    pending_picks;

  // Sender pacing
  int                    jets_sent  = 0;
  int                    burst_left = 0;
  bit                    steady     = 1'b0;

  // Long hold-off request, toggled by the stimulus
  logic                  hold_req   = 1'b0;

  best_two_tagged_jet_select dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  bttj_pick_checker chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tlast      (in_tlast),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .mismatches    (mismatches),
    .pending_picks (pending_picks)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Receiver: stall pattern in segments, plus a long hold-off on request
  always @(posedge clk) begin
    static logic     hold_seen = 1'b0;
    static int       hold_left = 0;
    static int       seg_left  = 0;
    static int       beat      = 0;
    static rx_mode_e rx_mode   = RX_OPEN;
    beat++;
    if (hold_seen != hold_req) begin
      hold_seen = hold_req;
      hold_left = LONG_HOLD;
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      if (seg_left == 0) begin
        rx_mode  = rx_mode_e'($urandom_range(0, 3));
        seg_left = $urandom_range(16, 160);
      end else begin
        seg_left--;
      end
      case (rx_mode)
        RX_OPEN:   out_tready <= 1'b1;
        RX_COIN:   out_tready <= 1'($urandom);
        RX_SPARSE: out_tready <= ($urandom_range(0, 7) == 0);
        default:   out_tready <= ((beat % 8) < 5);
      endcase
    end
  end

  function automatic in_word_t jet(input logic [TAG_W-1:0] tag, input logic [MOM_W-1:0] mom,
                                   input logic last);
    in_word_t w;
    w.tag_bits     = tag;
    w.jet_momentum = mom;
    w.last_jet     = last;
    return w;
  endfunction

  // Offer one jet word until taken; in_tready is sampled mid-cycle
  task automatic send_jet(input in_word_t w);
    logic rdy;
    int   gap;
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_DATA_W - TAG_W - MOM_W){1'b0}}, w.jet_momentum, w.tag_bits};
    in_tlast  <= w.last_jet;
    do begin
      @(negedge clk);
      rdy = in_tready;
      @(posedge clk);
    end while (!rdy);
    jets_sent++;
    if (!steady) begin
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        burst_left = $urandom_range(1, 24);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        if ($urandom_range(0, 15) == 0)
          gap = $urandom_range(10, 40);
        if (gap > 0) begin
          in_tvalid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  endtask

  // Drop valid and wait until every pick is taken or DRAIN_LIMIT runs out, then idle
  task automatic drain();
    int n;
    n = 0;
    in_tvalid <= 1'b0;
    do begin
      @(negedge clk);
      n++;
    end while (pending_picks != 0 && n < DRAIN_LIMIT);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_mode(input logic alt);
    cfg_we    <= 1'b1;
    cfg_wdata <= alt;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // One event of random jets; small momenta give frequent ties
  task automatic random_event(input int len);
    in_word_t         w;
    logic [MOM_W-1:0] mom;
    for (int k = 0; k < len; k++) begin
      case ($urandom_range(0, 9))
        0:       mom = '0;
        1:       mom = '1;
        2, 3:    mom = MOM_W'($urandom_range(0, 3));
        default: mom = MOM_W'($urandom);
      endcase
      w = jet(TAG_W'($urandom), mom, k == len - 1);
      send_jet(w);
    end
  endtask

  // Mostly short events; a few run up to and past the jet limit
  function automatic int event_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 4)
      return $urandom_range(MAX_JETS_DEF - 2, MAX_JETS_DEF + 8);
    if (r < 12)
      return $urandom_range(1, 2);
    return $urandom_range(2, 12);
  endfunction

  task automatic random_phase(input logic alt, input int jets);
    int stop_at;
    drain();
    write_mode(alt);
    stop_at = jets_sent + jets;
    while (jets_sent < stop_at)
      random_event(event_len());
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed, bit-1 tag
    write_mode(1'b0);
    send_jet(jet(6'h3F, 16'hFFFF, 1'b1));                        // lone jet, nothing found
    send_jet(jet(6'h00, 16'd100, 1'b0));                         // equal momenta
    send_jet(jet(6'h00, 16'd100, 1'b1));
    send_jet(jet(TAG_MASK_LOOSE, 16'd5, 1'b0));                  // tag beats momentum
    send_jet(jet(6'h00, 16'hFFFF, 1'b0));
    send_jet(jet(6'h3D, 16'd60000, 1'b1));
    send_jet(jet(6'h3F, 16'd0, 1'b0));                           // zero momenta, mixed tags
    send_jet(jet(TAG_MASK_ALT, 16'd0, 1'b0));
    send_jet(jet(TAG_MASK_LOOSE, 16'd0, 1'b0));
    send_jet(jet(6'h00, 16'd1, 1'b1));
    send_jet(jet(6'h00, 16'd10, 1'b0));                          // best displaced twice
    send_jet(jet(6'h00, 16'd20, 1'b0));
    send_jet(jet(6'h00, 16'd30, 1'b1));

    // Directed, bit-4 tag
    drain();
    write_mode(1'b1);
    send_jet(jet(TAG_MASK_LOOSE, 16'hFFFF, 1'b0));
    send_jet(jet(TAG_MASK_ALT, 16'd1, 1'b0));
    send_jet(jet(6'h2D, 16'd2, 1'b1));
    send_jet(jet(6'h00, 16'd0, 1'b1));
    send_jet(jet(6'h3F, 16'h8000, 1'b0));
    send_jet(jet(6'h2F, 16'h8000, 1'b1));

    // Random phases; after the first come limit events and a long receiver hold-off
    random_phase(1'b0, RANDOM_JETS / 4);
    drain();
    write_mode(1'b1);
    random_event(MAX_JETS_DEF);
    random_event(MAX_JETS_DEF + 1);
    hold_req <= ~hold_req;
    steady = 1'b1;
    repeat (RANDOM_JETS / 4 / 8) random_event($urandom_range(2, 8));
    steady = 1'b0;
    random_phase(1'b0, RANDOM_JETS / 4);
    random_phase(1'b1, RANDOM_JETS / 4);

    drain();
    if (mismatches == 0 && pending_picks == 0) begin
      $display("best_two_tagged_jet_select test passed");
    end else begin
      $display("best_two_tagged_jet_select test failed");
    end
    $finish;
  end

  // Run limit
  initial begin
    #2000000;
    $display("best_two_tagged_jet_select test failed");
    $finish;
  end

endmodule
